// ----- hw/rtl/activation_derivative_unit_defines.svh -----
`ifndef ACTIVATION_DERIVATIVE_UNIT_DEFINES_SVH
`define ACTIVATION_DERIVATIVE_UNIT_DEFINES_SVH

// check while out of reset
`define ADU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define ADU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/adu_pkg.sv -----
`default_nettype none

package adu_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TABLE_STEPS = 256;
  localparam int FRAC_BITS   = 12;
  localparam int ROM_DEPTH   = TABLE_STEPS + 1;
  localparam int IDX_W       = $clog2(ROM_DEPTH);
  localparam int FRAC_W      = FRAC_BITS + 3 - $clog2(TABLE_STEPS);
  localparam int ROM_W       = FRAC_BITS + 1;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int LEAK_SLOPE  = ((1 << FRAC_BITS) + 50) / 100;
  localparam int LK_W        = $clog2(LEAK_SLOPE + 1) + 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [1:0] FN_SIGMOID = 2'd0;
  localparam logic [1:0] FN_TANH    = 2'd1;
  localparam logic [1:0] FN_RELU    = 2'd2;
  localparam logic [1:0] FN_LEAKY   = 2'd3;

  localparam logic REG_FSEL  = 1'b0;
  localparam logic REG_DMODE = 1'b1;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [63:0] TABLE_H = (Q62_ONE / 64'(TABLE_STEPS)) * 64'd8;

  typedef logic [ROM_W-1:0] rom_t [ROM_DEPTH];

  typedef struct packed {
    logic [1:0] fsel;
    logic       dmode;
  } adu_cfg_t;

  typedef struct packed {
    logic                neg;
    logic [SAMPLE_W-1:0] x;
    logic [1:0]          fsel;
    logic                dmode;
  } adu_ctl_t;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [ROM_W-1:0] ratio(input logic [63:0] num, input logic [63:0] den);
    logic [64:0]    r;
    logic [ROM_W:0] q;
    logic [ROM_W:0] qr;
    r = {1'b0, num};
    q = '0;
    for (int i = 0; i <= FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    qr = (q + 1'b1) >> 1;
    return qr[ROM_W-1:0];
  endfunction

  function automatic rom_t build_rom(input logic is_tanh);
    rom_t        rom;
    logic [63:0] term;
    logic [63:0] step;
    logic [63:0] e;
    logic [63:0] e2;
    term = Q62_ONE;
    step = Q62_ONE;
    e    = Q62_ONE;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64(q62_mul(term, TABLE_H), 64'(n));
      if (n % 2 == 1) step = step - term;
      else step = step + term;
    end
    for (int k = 0; k < ROM_DEPTH; k++) begin
      e2 = q62_mul(e, e);
      if (is_tanh) rom[k] = ratio(Q62_ONE - e2, Q62_ONE + e2);
      else rom[k] = ratio(Q62_ONE, Q62_ONE + e);
      e = q62_mul(e, step);
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM  = build_rom(1'b0);
  localparam rom_t TANH_ROM = build_rom(1'b1);

endpackage

`default_nettype wire

// ----- hw/rtl/adu_cfg.sv -----
`default_nettype none

module adu_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adu_pkg::PADDR_W-1:0]   paddr,
  input  logic [adu_pkg::PDATA_W-1:0]   pwdata,
  output logic [adu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output adu_pkg::adu_cfg_t             cfg
);
  import adu_pkg::*;

  logic [1:0] fsel_r;
  logic       dmode_r;
  logic       wr_en;
  logic       reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r  <= FN_SIGMOID;
      dmode_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FSEL:  fsel_r  <= pwdata[1:0];
        REG_DMODE: dmode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FSEL:  prdata = {{(PDATA_W-2){1'b0}}, fsel_r};
      REG_DMODE: prdata = {{(PDATA_W-1){1'b0}}, dmode_r};
      default:   prdata = '0;
    endcase
  end

  assign cfg.fsel  = fsel_r;
  assign cfg.dmode = dmode_r;

endmodule

`default_nettype wire

// ----- hw/rtl/adu_index.sv -----
`default_nettype none

module adu_index (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  logic [adu_pkg::SAMPLE_W-1:0]   sample,
  input  adu_pkg::adu_cfg_t              cfg,
  output logic                           s1_vld,
  output adu_pkg::adu_ctl_t              s1_ctl,
  output logic [adu_pkg::IDX_W-1:0]      s1_idx,
  output logic [adu_pkg::FRAC_W-1:0]     s1_frac
);
  import adu_pkg::*;

  logic [SAMPLE_W:0]   x_ext;
  logic [SAMPLE_W:0]   ax_full;
  logic [SAMPLE_W-1:0] ax;
  logic [IDX_W-1:0]    idx_nxt;
  logic [FRAC_W-1:0]   frac_nxt;
  adu_ctl_t            ctl_nxt;

  logic                vld_r;
  adu_ctl_t            ctl_r;
  logic [IDX_W-1:0]    idx_r;
  logic [FRAC_W-1:0]   frac_r;

  assign x_ext    = {sample[SAMPLE_W-1], sample};
  assign ax_full  = sample[SAMPLE_W-1] ? (~x_ext + 1'b1) : x_ext;
  assign ax       = ax_full[SAMPLE_W-1:0];
  assign idx_nxt  = IDX_W'(ax >> FRAC_W);
  assign frac_nxt = ax[FRAC_W-1:0];

  assign ctl_nxt.neg   = sample[SAMPLE_W-1];
  assign ctl_nxt.x     = sample;
  assign ctl_nxt.fsel  = cfg.fsel;
  assign ctl_nxt.dmode = cfg.dmode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r  <= ctl_nxt;
      idx_r  <= idx_nxt;
      frac_r <= frac_nxt;
    end
  end

  assign s1_vld  = vld_r;
  assign s1_ctl  = ctl_r;
  assign s1_idx  = idx_r;
  assign s1_frac = frac_r;

endmodule

`default_nettype wire

// ----- hw/rtl/adu_interp.sv -----
`default_nettype none

module adu_interp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         s1_vld,
  input  adu_pkg::adu_ctl_t            s1_ctl,
  input  logic [adu_pkg::IDX_W-1:0]    s1_idx,
  input  logic [adu_pkg::FRAC_W-1:0]   s1_frac,
  output logic                         s3_vld,
  output adu_pkg::adu_ctl_t            s3_ctl,
  output logic [adu_pkg::ROM_W-1:0]    s3_mag
);
  import adu_pkg::*;

  logic                    is_tanh;
  logic                    last;
  logic [IDX_W-1:0]        idx_hi;
  logic [ROM_W-1:0]        lo_nxt;
  logic [ROM_W-1:0]        hi_val;
  logic [ROM_W-1:0]        dif_nxt;

  logic                    vld2_r;
  adu_ctl_t                ctl2_r;
  logic [ROM_W-1:0]        lo_r;
  logic [ROM_W-1:0]        dif_r;
  logic [FRAC_W-1:0]       frac_r;

  logic [ROM_W+FRAC_W-1:0] prod;
  logic [ROM_W-1:0]        mag_nxt;

  logic                    vld3_r;
  adu_ctl_t                ctl3_r;
  logic [ROM_W-1:0]        mag_r;

  // table read
  assign is_tanh = (s1_ctl.fsel == FN_TANH);
  assign last    = (s1_idx == IDX_W'(TABLE_STEPS));
  assign idx_hi  = s1_idx + 1'b1;
  assign lo_nxt  = is_tanh ? TANH_ROM[s1_idx] : SIG_ROM[s1_idx];
  assign hi_val  = last ? lo_nxt : (is_tanh ? TANH_ROM[idx_hi] : SIG_ROM[idx_hi]);
  assign dif_nxt = hi_val - lo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= s1_vld;
      vld3_r <= vld2_r;
    end
  end

  // interpolate, truncating
  assign prod    = {{FRAC_W{1'b0}}, dif_r} * {{ROM_W{1'b0}}, frac_r};
  assign mag_nxt = lo_r + ROM_W'(prod >> FRAC_W);

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl2_r <= s1_ctl;
      lo_r   <= lo_nxt;
      dif_r  <= dif_nxt;
      frac_r <= s1_frac;
      ctl3_r <= ctl2_r;
      mag_r  <= mag_nxt;
    end
  end

  assign s3_vld = vld3_r;
  assign s3_ctl = ctl3_r;
  assign s3_mag = mag_r;

endmodule

`default_nettype wire

// ----- hw/rtl/adu_shape.sv -----
`default_nettype none

module adu_shape (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          s3_vld,
  input  adu_pkg::adu_ctl_t             s3_ctl,
  input  logic [adu_pkg::ROM_W-1:0]     s3_mag,
  output logic                          out_vld,
  output logic [adu_pkg::SAMPLE_W-1:0]  out_sample
);
  import adu_pkg::*;

  localparam int V_W  = ROM_W + 1;
  localparam int P_W  = 2 * ROM_W;
  localparam int L_W  = SAMPLE_W + LK_W;
  localparam int Y_W  = SAMPLE_W + 2;

  localparam logic signed [Y_W-1:0] MAX_Y  = Y_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [Y_W-1:0] MIN_Y  = -Y_W'(2 ** (SAMPLE_W - 1));
  localparam logic signed [Y_W-1:0] ONE_Y  = Y_W'(ONE);
  localparam logic signed [Y_W-1:0] LEAK_Y = Y_W'(LEAK_SLOPE);
  localparam logic signed [LK_W-1:0] SLOPE = LK_W'(LEAK_SLOPE);

  logic [ROM_W-1:0]        comp;
  logic signed [V_W-1:0]   mag_s;
  logic signed [V_W-1:0]   v_nxt;
  logic [ROM_W-1:0]        ma;
  logic [ROM_W-1:0]        mb;
  logic [P_W-1:0]          prod_nxt;
  logic signed [L_W-1:0]   lk_nxt;

  logic                    vld4_r;
  adu_ctl_t                ctl4_r;
  logic signed [V_W-1:0]   v_r;
  logic [P_W-1:0]          prod_r;
  logic signed [L_W-1:0]   lk_r;

  logic [P_W-1:0]          psh;
  logic signed [Y_W-1:0]   pq;
  logic signed [Y_W-1:0]   v_y;
  logic signed [Y_W-1:0]   x_y;
  logic signed [L_W-1:0]   lk_sh;
  logic signed [Y_W-1:0]   lk_y;
  logic signed [Y_W-1:0]   y;
  logic [SAMPLE_W-1:0]     res_nxt;

  logic                    vld5_r;
  logic [SAMPLE_W-1:0]     res_r;

  // symmetry and derivative product
  assign comp  = ROM_W'(ONE) - s3_mag;
  assign mag_s = $signed({1'b0, s3_mag});

  always_comb begin
    case (s3_ctl.fsel)
      FN_SIGMOID: v_nxt = s3_ctl.neg ? $signed({1'b0, comp}) : mag_s;
      FN_TANH:    v_nxt = s3_ctl.neg ? -mag_s : mag_s;
      default:    v_nxt = '0;
    endcase
  end

  assign ma       = (s3_ctl.fsel == FN_SIGMOID && s3_ctl.neg) ? comp : s3_mag;
  assign mb       = (s3_ctl.fsel == FN_SIGMOID) ? (s3_ctl.neg ? s3_mag : comp) : s3_mag;
  assign prod_nxt = {{ROM_W{1'b0}}, ma} * {{ROM_W{1'b0}}, mb};
  assign lk_nxt   = L_W'($signed(s3_ctl.x)) * L_W'(SLOPE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (adv) begin
      vld4_r <= s3_vld;
      vld5_r <= vld4_r;
    end
  end

  // final select and clamp
  assign psh   = prod_r >> FRAC_BITS;
  assign pq    = $signed({{(Y_W-ROM_W){1'b0}}, psh[ROM_W-1:0]});
  assign v_y   = $signed({{(Y_W-V_W){v_r[V_W-1]}}, v_r});
  assign x_y   = $signed({{(Y_W-SAMPLE_W){ctl4_r.x[SAMPLE_W-1]}}, ctl4_r.x});
  assign lk_sh = lk_r >>> FRAC_BITS;
  assign lk_y  = $signed(lk_sh[Y_W-1:0]);

  always_comb begin
    case (ctl4_r.fsel)
      FN_SIGMOID: y = ctl4_r.dmode ? pq : v_y;
      FN_TANH:    y = ctl4_r.dmode ? (ONE_Y - pq) : v_y;
      FN_RELU: begin
        if (ctl4_r.dmode) y = ctl4_r.neg ? '0 : ONE_Y;
        else y = ctl4_r.neg ? '0 : x_y;
      end
      FN_LEAKY: begin
        if (ctl4_r.dmode) y = ctl4_r.neg ? LEAK_Y : ONE_Y;
        else y = ctl4_r.neg ? lk_y : x_y;
      end
      default: y = '0;
    endcase
  end

  always_comb begin
    if (y > MAX_Y) res_nxt = MAX_Y[SAMPLE_W-1:0];
    else if (y < MIN_Y) res_nxt = MIN_Y[SAMPLE_W-1:0];
    else res_nxt = y[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl4_r <= s3_ctl;
      v_r    <= v_nxt;
      prod_r <= prod_nxt;
      lk_r   <= lk_nxt;
      res_r  <= res_nxt;
    end
  end

  assign out_vld    = vld5_r;
  assign out_sample = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/activation_derivative_unit.sv -----
// Channel   Direction  Handshake          Payload
// in        in         in_valid/in_stall  in_sample_in  (Q4.12, signed)
// out       out        out_valid/out_stall out_sample_out (Q4.12, signed)
// config    in         psel/penable       paddr/pwdata/prdata, pready tied high
//
// One word per cycle while no output word waits; words leave in input order.
// Five register stages: index, table read, interpolate, symmetry/product, select.
// Reset clears the valid bits and both config registers; tables are constant.
// A waiting output word stalls every stage at once; nothing moves or drops.
// in_stall is high exactly while out_valid is high and out_stall is high.
`default_nettype none

`include "activation_derivative_unit_defines.svh"

module activation_derivative_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sample_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import adu_pkg::*;

  adu_cfg_t             cfg;
  logic                 adv;
  logic                 s1_vld;
  adu_ctl_t             s1_ctl;
  logic [IDX_W-1:0]     s1_idx;
  logic [FRAC_W-1:0]    s1_frac;
  logic                 s3_vld;
  adu_ctl_t             s3_ctl;
  logic [ROM_W-1:0]     s3_mag;

  // advance the whole pipe unless the output word waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  adu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  adu_index u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .sample  (in_sample_in),
    .cfg     (cfg),
    .s1_vld  (s1_vld),
    .s1_ctl  (s1_ctl),
    .s1_idx  (s1_idx),
    .s1_frac (s1_frac)
  );

  adu_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_vld  (s1_vld),
    .s1_ctl  (s1_ctl),
    .s1_idx  (s1_idx),
    .s1_frac (s1_frac),
    .s3_vld  (s3_vld),
    .s3_ctl  (s3_ctl),
    .s3_mag  (s3_mag)
  );

  adu_shape u_shape (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .s3_vld     (s3_vld),
    .s3_ctl     (s3_ctl),
    .s3_mag     (s3_mag),
    .out_vld    (out_valid),
    .out_sample (out_sample_out)
  );

  `ADU_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
  `ADU_ASSERT(a_stall_full, in_stall |-> out_valid, "input stalled with no output word")
  `ADU_ASSERT(a_hold_s1, !adv |=> $stable(s1_vld), "first stage moved while stalled")
  `ADU_ASSERT(a_mag_range, s3_vld |-> (s3_mag <= ROM_W'(ONE)), "interpolated value above one")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import adu_pkg::*;

  localparam longint UNITY = 4096;
  localparam longint FB    = 12;
  localparam longint STEPS = 256;
  localparam longint SPAN  = 32768;
  localparam longint LEAK  = 41;
  localparam int     WORDS_PER_SETTING = 180;
  localparam int     HOLD_OFF_CYCLES   = 64;

  typedef struct packed {
    logic [1:0]  fsel;
    logic        dmode;
    logic [15:0] sample;
    logic        typed;
    logic [15:0] want;
  } plan_row_t;

  localparam plan_row_t PLAN [25] = '{
    '{FN_SIGMOID, 1'b0, 16'h0000, 1'b1, 16'd2048},
    '{FN_SIGMOID, 1'b0, 16'h7FFF, 1'b0, 16'h0000},
    '{FN_SIGMOID, 1'b0, 16'h8000, 1'b0, 16'h0000},
    '{FN_SIGMOID, 1'b0, 16'h0080, 1'b0, 16'h0000},
    '{FN_SIGMOID, 1'b0, 16'hFF80, 1'b0, 16'h0000},
    '{FN_SIGMOID, 1'b0, 16'h0001, 1'b0, 16'h0000},
    '{FN_SIGMOID, 1'b1, 16'h0000, 1'b1, 16'd1024},
    '{FN_SIGMOID, 1'b1, 16'h8000, 1'b0, 16'h0000},
    '{FN_SIGMOID, 1'b1, 16'h7FFF, 1'b0, 16'h0000},
    '{FN_TANH,    1'b0, 16'h0000, 1'b1, 16'd0},
    '{FN_TANH,    1'b0, 16'h8000, 1'b0, 16'h0000},
    '{FN_TANH,    1'b0, 16'h7FFF, 1'b0, 16'h0000},
    '{FN_TANH,    1'b0, 16'h00C1, 1'b0, 16'h0000},
    '{FN_TANH,    1'b1, 16'h0000, 1'b1, 16'd4096},
    '{FN_TANH,    1'b1, 16'hFFFF, 1'b0, 16'h0000},
    '{FN_RELU,    1'b0, 16'h7FFF, 1'b1, 16'h7FFF},
    '{FN_RELU,    1'b0, 16'h8000, 1'b1, 16'h0000},
    '{FN_RELU,    1'b0, 16'h0000, 1'b1, 16'h0000},
    '{FN_RELU,    1'b1, 16'h0000, 1'b1, 16'd4096},
    '{FN_RELU,    1'b1, 16'hFFFF, 1'b1, 16'h0000},
    '{FN_LEAKY,   1'b0, 16'h8000, 1'b1, 16'hFEB8},
    '{FN_LEAKY,   1'b0, 16'hFFFF, 1'b1, 16'hFFFF},
    '{FN_LEAKY,   1'b0, 16'h7FFF, 1'b1, 16'h7FFF},
    '{FN_LEAKY,   1'b1, 16'hFFFB, 1'b1, 16'd41},
    '{FN_LEAKY,   1'b1, 16'h0000, 1'b1, 16'd4096}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_sample_in;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_sample_out;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  activation_derivative_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longint      sig_tab  [0:256];
  longint      tanh_tab [0:256];
  logic [1:0]  cfg_fsel = FN_SIGMOID;
  logic        cfg_dmode = 1'b0;
  logic [15:0] pending_activations [$];
  logic [15:0] want;
  logic        next_typed = 1'b0;
  logic [15:0] next_want = '0;
  logic        hold_req = 1'b0;
  int          errors = 0;
  int          checked = 0;
  int          settings_used = 0;
  int          held_cycles = 0;

  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> 62);
  endfunction

  function automatic longint round_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [15:0] q;
    r = {1'b0, num};
    q = '0;
    for (int i = 0; i <= FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return longint'((q + 16'd1) >> 1);
  endfunction

  function automatic void build_tables();
    logic [63:0] one62;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] decay;
    logic [63:0] e;
    logic [63:0] e2;
    one62 = 64'd1 << 62;
    h = (one62 / 64'(STEPS)) * 64'd8;
    term = one62;
    decay = one62;
    e = one62;
    for (int n = 1; n <= 24; n++) begin
      term = q62_product(term, h) / 64'(n);
      if (n % 2 == 1) decay = decay - term;
      else decay = decay + term;
    end
    for (int k = 0; k <= STEPS; k++) begin
      e2 = q62_product(e, e);
      sig_tab[k] = round_ratio(one62, one62 + e);
      tanh_tab[k] = round_ratio(one62 - e2, one62 + e2);
      e = q62_product(e, decay);
    end
  endfunction

  function automatic longint interp(input logic use_tanh, input longint ax);
    longint pos;
    longint idx;
    longint frac;
    longint lo;
    longint hi;
    pos = ax * STEPS;
    idx = pos / SPAN;
    frac = pos % SPAN;
    if (idx >= STEPS) return use_tanh ? tanh_tab[STEPS] : sig_tab[STEPS];
    lo = use_tanh ? tanh_tab[idx] : sig_tab[idx];
    hi = use_tanh ? tanh_tab[idx + 1] : sig_tab[idx + 1];
    return lo + ((hi - lo) * frac) / SPAN;
  endfunction

  function automatic logic [15:0] activation_value(input logic [15:0] word);
    longint x;
    longint ax;
    longint v;
    longint y;
    x = longint'($signed(word));
    ax = (x < 0) ? -x : x;
    case (cfg_fsel)
      FN_SIGMOID: begin
        v = interp(1'b0, ax);
        if (x < 0) v = UNITY - v;
        y = cfg_dmode ? ((v * (UNITY - v)) >>> FB) : v;
      end
      FN_TANH: begin
        v = interp(1'b1, ax);
        if (x < 0) v = -v;
        y = cfg_dmode ? (UNITY - ((v * v) >>> FB)) : v;
      end
      FN_RELU: begin
        if (cfg_dmode) y = (x < 0) ? 0 : UNITY;
        else y = (x < 0) ? 0 : x;
      end
      FN_LEAKY: begin
        if (cfg_dmode) y = (x < 0) ? LEAK : UNITY;
        else if (x < 0) y = -(((-x) * LEAK + (UNITY - 1)) >>> FB);
        else y = x;
      end
      default: y = 0;
    endcase
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] mag;
    logic        neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: mag = 16'($urandom_range(0, 700));
      3: mag = 16'($urandom_range(32640, 32767));
      4: mag = 16'($urandom_range(0, 255) << 7) | ($urandom_range(0, 1) ? 16'd127 : 16'd0);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
    return neg ? -mag : mag;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_activations.push_back(next_typed ? next_want : activation_value(in_sample_in));
    if (rst_n && out_valid && !out_stall) begin
      checked++;
      if (pending_activations.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, out_sample_out);
      end else begin
        want = pending_activations.pop_front();
        if (out_sample_out !== want) begin
          errors++;
          $display("%0t: sample_out expected %h, got %h", $time, want, out_sample_out);
        end
      end
    end
  end

  initial begin
    int mode;
    int span_left;
    int period;
    int on_len;
    int tick;
    int hold_left;
    mode = 0;
    span_left = 0;
    period = 1;
    on_len = 0;
    tick = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        held_cycles = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (span_left == 0) begin
        mode = $urandom_range(0, 3);
        span_left = $urandom_range(20, 200);
        period = $urandom_range(2, 9);
        on_len = $urandom_range(1, period - 1);
      end
      span_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ((tick % period) < on_len);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_mode(input logic [1:0] fsel, input logic dmode);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_activations.size() != 0) @(posedge clk);
    cfg_write(REG_FSEL, 32'(fsel));
    cfg_write(REG_DMODE, 32'(dmode));
    cfg_fsel = fsel;
    cfg_dmode = dmode;
    settings_used++;
  endtask

  task automatic send_word(input logic [15:0] sample, input logic typed,
                           input logic [15:0] typed_want);
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_in <= sample;
    next_typed = typed;
    next_want = typed_want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  initial begin
    logic [2:0] order [8];
    logic [2:0] swap;
    int         j;
    int         burst_left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    build_tables();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].fsel != cfg_fsel || PLAN[i].dmode != cfg_dmode)
        set_mode(PLAN[i].fsel, PLAN[i].dmode);
      send_word(PLAN[i].sample, PLAN[i].typed, PLAN[i].want);
    end

    for (int i = 0; i < 8; i++) order[i] = 3'(i);
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end

    burst_left = 0;
    for (int p = 0; p < 8; p++) begin
      set_mode(order[p][2:1], order[p][0]);
      if (p == 2) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_SETTING; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
        end
        burst_left--;
        send_word(pick_sample(), 1'b0, 16'h0000);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_activations.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Checked %0d words over %0d register settings (all functions and derivatives),",
             checked, settings_used);
    $display("with bursty input, random output stalls and one %0d-cycle output hold-off.",
             held_cycles);
    if (errors == 0) begin
      $display("activation_derivative_unit test passed");
    end else begin
      $display("activation_derivative_unit test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("activation_derivative_unit test failed");
    $finish;
  end

endmodule

// ----- activation_derivative_unit.f -----
+incdir+hw/rtl
hw/rtl/adu_pkg.sv
hw/rtl/adu_cfg.sv
hw/rtl/adu_index.sv
hw/rtl/adu_interp.sv
hw/rtl/adu_shape.sv
hw/rtl/activation_derivative_unit.sv
bench/testbench.sv
